/* hdl/lgs_pkg.sv */
package lgs_pkg;

  // Width of the row and column fields that travel to every row cell
  localparam int unsigned IDX_W = 8;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2
  } opcode_e;

  // Control word broadcast from the sequencer to all row cells
  typedef struct packed {
    logic             shift;  // rotate rows one place toward cell 0
    logic             wr;     // write one cell, already clipped to the grid in use
    logic             rd;     // read one cell, already clipped to the grid in use
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             val;
  } cell_ctrl_t;

endpackage

/* hdl/lgs_row_cell.sv */
module lgs_row_cell #(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned ROW_IDX  = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lgs_pkg::cell_ctrl_t   ctrl_i,
  input  logic [MAX_COLS-1:0]   shift_row_i,
  output logic [MAX_COLS-1:0]   row_o,
  output logic                  rd_bit_o
);

  localparam int unsigned CIDX_W = $clog2(MAX_COLS);

  logic [MAX_COLS-1:0] row_d, row_q;
  logic [CIDX_W-1:0]   col_idx;
  logic                row_hit;

  assign col_idx = ctrl_i.col[CIDX_W-1:0];
  assign row_hit = (ctrl_i.row == lgs_pkg::IDX_W'(ROW_IDX));

  // Rotate during a generation, else single-cell write
  always_comb begin
    row_d = row_q;
    if (ctrl_i.shift) begin
      row_d = shift_row_i;
    end else if (ctrl_i.wr && row_hit) begin
      row_d[col_idx] = ctrl_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o    = row_q;
  assign rd_bit_o = ctrl_i.rd & row_hit & row_q[col_idx];

endmodule

/* hdl/lgs_row_update.sv */
module lgs_row_update #(
  parameter int unsigned MAX_COLS = 64
) (
  input  logic [MAX_COLS-1:0] above_i,
  input  logic [MAX_COLS-1:0] cur_i,
  input  logic [MAX_COLS-1:0] below_i,
  input  logic                above_ok_i,
  input  logic                below_ok_i,
  input  logic                row_active_i,
  input  logic [6:0]          cols_i,
  output logic [MAX_COLS-1:0] row_o
);

  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS+1:0] a_pad, c_pad, b_pad;

  // Columns in use; cells beyond them count as dead
  for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
    assign col_mask[c] = (9'(c) < {2'b00, cols_i});
  end

  assign a_pad = {1'b0, above_i & col_mask & {MAX_COLS{above_ok_i}}, 1'b0};
  assign c_pad = {1'b0, cur_i & col_mask, 1'b0};
  assign b_pad = {1'b0, below_i & col_mask & {MAX_COLS{below_ok_i}}, 1'b0};

  // One B3/S23 lane per column
  for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
    logic [3:0] n;
    logic       next;
    assign n = 4'(a_pad[c]) + 4'(a_pad[c+1]) + 4'(a_pad[c+2]) +
               4'(c_pad[c]) + 4'(c_pad[c+2]) +
               4'(b_pad[c]) + 4'(b_pad[c+1]) + 4'(b_pad[c+2]);
    assign next = (n == 4'd3) || (cur_i[c] && (n == 4'd2));
    assign row_o[c] = (row_active_i && col_mask[c]) ? next : cur_i[c];
  end

endmodule

/* hdl/life_grid_generation_step.sv */
// Channel   Dir  Fields (low bit up)
// s_axis    in   opcode[1:0] col[8:2] row[15:9] cell_value[16]
// m_axis    out  read_value[0] op_done[2:1]
// cfg       in   index 0 cols_in_use, index 1 rows_in_use (7 bits)
//
// Write, read and unused opcodes complete when accepted; a generation rotates all
// MAX_ROWS rows through the cell chain, one row per cycle.
// Reset clears every cell and loads 64 into both size registers.
// A two-entry output stage lets one more item in while a result waits; input
// is held off during a generation and while both output entries are full.
module life_grid_generation_step #(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // opcode, col, row, cell_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // read_value, op_done
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i
);

  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam logic [RW-1:0] LAST_ROW = RW'(MAX_ROWS - 1);

  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_STEP = 2'b10
  } state_e;

  state_e state_d, state_q;
  logic [RW-1:0]  cnt_d, cnt_q;
  logic [6:0]     cols_q, rows_q;
  logic [MAX_COLS-1:0] prev_q;

  logic [1:0] in_op;
  logic [6:0] in_col, in_row;
  logic       in_val;
  logic [8:0] col9, row9;
  logic       in_grid, in_fire;

  lgs_pkg::cell_ctrl_t ctrl;
  logic [MAX_ROWS-1:0][MAX_COLS-1:0] rows;
  logic [MAX_ROWS-1:0] rd_bits;
  logic [MAX_COLS-1:0] new_row;

  logic       res_vld;
  logic [2:0] res_dat;
  logic       m_vld_d, m_vld_q, sk_vld_d, sk_vld_q;
  logic [2:0] m_dat_d, m_dat_q, sk_dat_d, sk_dat_q;

  logic [8:0] cnt9, nxt9;

  // Input unpack and clipping to the grid in use
  assign in_op   = s_axis_tdata[1:0];
  assign in_col  = s_axis_tdata[8:2];
  assign in_row  = s_axis_tdata[15:9];
  assign in_val  = s_axis_tdata[16];
  assign col9    = {2'b00, in_col};
  assign row9    = {2'b00, in_row};
  assign in_grid = (col9 < 9'(MAX_COLS)) && (in_col < cols_q) &&
                   (row9 < 9'(MAX_ROWS)) && (in_row < rows_q);

  assign s_axis_tready = (state_q == ST_IDLE) && !sk_vld_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 7'd64;
      rows_q <= 7'd64;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_COLS) cols_q <= cfg_data_i;
      if (cfg_idx_i == CFG_ROWS) rows_q <= cfg_data_i;
    end
  end

  // Broadcast control to the cell chain
  assign ctrl.shift = (state_q == ST_STEP);
  assign ctrl.wr    = in_fire && (in_op == lgs_pkg::OP_WRITE) && in_grid;
  assign ctrl.rd    = (in_op == lgs_pkg::OP_READ) && in_grid;
  assign ctrl.row   = row9[lgs_pkg::IDX_W-1:0];
  assign ctrl.col   = col9[lgs_pkg::IDX_W-1:0];
  assign ctrl.val   = in_val;

  // Row cells: cell k holds row k when idle; the chain rotates toward cell 0
  for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
    logic [MAX_COLS-1:0] shift_in;
    if (k == MAX_ROWS - 1) begin : g_tail
      assign shift_in = new_row;
    end else begin : g_body
      assign shift_in = rows[k+1];
    end
    lgs_row_cell #(
      .MAX_COLS (MAX_COLS),
      .ROW_IDX  (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .shift_row_i (shift_in),
      .row_o       (rows[k]),
      .rd_bit_o    (rd_bits[k])
    );
  end

  // New value of the row now in cell 0 from old rows above and below
  assign cnt9 = {{(9 - RW){1'b0}}, cnt_q};
  assign nxt9 = cnt9 + 9'd1;

  lgs_row_update #(
    .MAX_COLS (MAX_COLS)
  ) u_update (
    .above_i      (prev_q),
    .cur_i        (rows[0]),
    .below_i      (rows[1]),
    .above_ok_i   (cnt_q != '0),
    .below_ok_i   ((nxt9 < 9'(MAX_ROWS)) && (nxt9 < {2'b00, rows_q})),
    .row_active_i (cnt9 < {2'b00, rows_q}),
    .cols_i       (cols_q),
    .row_o        (new_row)
  );

  // Old copy of the row that just left cell 0
  always_ff @(posedge clk_i) begin
    if (ctrl.shift) prev_q <= rows[0];
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_op == lgs_pkg::OP_STEP)) begin
          state_d = ST_STEP;
          cnt_d   = '0;
        end
      end
      ST_STEP: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_ROW) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Result of this cycle
  always_comb begin
    res_vld = 1'b0;
    res_dat = '0;
    if (in_fire && (in_op != lgs_pkg::OP_STEP)) begin
      res_vld = 1'b1;
      res_dat = {in_op, |rd_bits};
    end else if ((state_q == ST_STEP) && (cnt_q == LAST_ROW)) begin
      res_vld = 1'b1;
      res_dat = {lgs_pkg::OP_STEP, 1'b0};
    end
  end

  // Output register plus skid entry
  always_comb begin
    m_vld_d  = m_vld_q;
    m_dat_d  = m_dat_q;
    sk_vld_d = sk_vld_q;
    sk_dat_d = sk_dat_q;
    if (m_vld_q && m_axis_tready) begin
      if (sk_vld_q) begin
        m_dat_d  = sk_dat_q;
        sk_vld_d = 1'b0;
      end else begin
        m_vld_d = 1'b0;
      end
    end
    if (res_vld) begin
      if (!m_vld_d) begin
        m_vld_d = 1'b1;
        m_dat_d = res_dat;
      end else begin
        sk_vld_d = 1'b1;
        sk_dat_d = res_dat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q  <= 1'b0;
      sk_vld_q <= 1'b0;
    end else begin
      m_vld_q  <= m_vld_d;
      sk_vld_q <= sk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_dat_q  <= m_dat_d;
    sk_dat_q <= sk_dat_d;
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {5'b00000, m_dat_q};

`ifndef SYNTHESIS
  a_step_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) && (cnt_q == LAST_ROW) |=> (state_q == ST_IDLE))
    else $error("generation did not end after the last row");

  a_step_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_op == lgs_pkg::OP_STEP) |=> (state_q == ST_STEP) && (cnt_q == '0))
    else $error("accepted step did not start a generation");

  a_no_accept_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> !s_axis_tready)
    else $error("input ready during a generation");

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_vld_q |-> m_vld_q)
    else $error("skid entry full while output register empty");
`endif

endmodule
